>>> rtl/stwd_pkg.sv
// Shared constants and types for the spike train word detector.
// No dependencies; every other file refers to this package by scoped names.

package stwd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int TIME_BITS     = 48;
    localparam int MAX_WORD_BITS = 16;
    localparam int WLEN_BITS     = 5;
    localparam int CNT_BITS      = $clog2(MAX_WORD_BITS + 1);
    localparam int CFG_DATA_BITS = 48;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RST   = '0;
    localparam logic [TIME_BITS-1:0]          BIN_LENGTH_RST  = TIME_BITS'(60000000);
    localparam logic [WLEN_BITS-1:0]          WORD_LENGTH_RST = WLEN_BITS'(4);
    localparam logic [MAX_WORD_BITS-1:0]      TARGET_WORD_RST = MAX_WORD_BITS'(4);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_BIN_LENGTH  = 2'd1,
        CFG_WORD_LENGTH = 2'd2,
        CFG_TARGET_WORD = 2'd3
    } cfg_idx_t;

    // One bit pushed into the word history for the current item.
    typedef struct packed {
        logic valid;
        logic bit_value;
    } insert_req_t;

endpackage

>>> rtl/stwd_if.sv
// Valid/ready channel interfaces for sample items and bin result items.
// Depends on stwd_pkg for field widths.

interface stwd_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [stwd_pkg::SAMPLE_BITS-1:0] sample;
    logic [stwd_pkg::TIME_BITS-1:0]          time_ns;

    modport source (output valid, output sample, output time_ns, input ready);
    modport sink   (input valid, input sample, input time_ns, output ready);
endinterface

interface stwd_result_if;
    logic valid;
    logic ready;
    logic word_detected;
    logic bin_bit;

    modport source (output valid, output word_detected, output bin_bit, input ready);
    modport sink   (input valid, input word_detected, input bin_bit, output ready);
endinterface

>>> rtl/spike_train_word_detector_top.sv
// Top level of the spike train word detector: config registers, spike and bin logic.
// Depends on stwd_pkg, the channel interfaces in stwd_if.sv and stwd_word_matcher.

// Each accepted sample item is handled in the cycle it is taken: the peak test,
// the 48-bit elapsed-time compare and the word match all settle before the
// edge, and a bin-end result is captured in the output register at that edge.
// One item is taken every cycle; the sample side stalls only while the output
// register holds a result that the sink has not taken. Configuration writes
// take effect on the next item and should be made while the block is idle.

module spike_train_word_detector_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [stwd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [stwd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    stwd_sample_if.sink                          samples,
    stwd_result_if.source                        results
);

    logic signed [stwd_pkg::SAMPLE_BITS-1:0] threshold_reg;
    logic [stwd_pkg::TIME_BITS-1:0]          bin_length_reg;
    logic [stwd_pkg::WLEN_BITS-1:0]          word_length_reg;
    logic [stwd_pkg::MAX_WORD_BITS-1:0]      target_word_reg;

    logic signed [stwd_pkg::SAMPLE_BITS-1:0] prev_sample_reg;
    logic signed [stwd_pkg::SAMPLE_BITS-1:0] prev_prev_sample_reg;
    logic                                    spike_in_bin_reg;
    logic                                    pending_start_reg;
    logic [stwd_pkg::TIME_BITS-1:0]          window_start_reg;

    logic                                    out_valid_reg;
    logic                                    word_detected_reg;
    logic                                    bin_bit_reg;

    logic                                    accept;
    logic [stwd_pkg::TIME_BITS-1:0]          start_time;
    logic [stwd_pkg::TIME_BITS-1:0]          elapsed;
    logic                                    spike;
    logic                                    first_spike;
    logic                                    spike_seen;
    logic                                    close;
    logic                                    match;
    stwd_pkg::insert_req_t                   insert;
    stwd_pkg::cfg_idx_t                      cfg_sel;

    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;

    assign start_time  = pending_start_reg ? samples.time_ns : window_start_reg;
    assign elapsed     = samples.time_ns - start_time;
    assign close       = elapsed > bin_length_reg;
    assign spike       = (prev_prev_sample_reg <= prev_sample_reg)
                      && (prev_sample_reg >= samples.sample)
                      && (prev_sample_reg > threshold_reg);
    assign first_spike = spike && !spike_in_bin_reg;
    assign spike_seen  = spike_in_bin_reg || first_spike;

    // A bin that closes without a spike records a zero.
    assign insert.valid     = accept && (first_spike || (close && !spike_seen));
    assign insert.bit_value = first_spike;

    stwd_word_matcher u_matcher
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .insert      (insert),
        .bin_close   (accept && close),
        .word_length (word_length_reg),
        .target_word (target_word_reg),
        .match       (match)
    );

    assign cfg_sel = stwd_pkg::cfg_idx_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= stwd_pkg::THRESHOLD_RST;
            bin_length_reg  <= stwd_pkg::BIN_LENGTH_RST;
            word_length_reg <= stwd_pkg::WORD_LENGTH_RST;
            target_word_reg <= stwd_pkg::TARGET_WORD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                stwd_pkg::CFG_THRESHOLD:
                    threshold_reg <= cfg_wdata[stwd_pkg::SAMPLE_BITS-1:0];
                stwd_pkg::CFG_BIN_LENGTH:
                    bin_length_reg <= cfg_wdata[stwd_pkg::TIME_BITS-1:0];
                stwd_pkg::CFG_WORD_LENGTH:
                    word_length_reg <= cfg_wdata[stwd_pkg::WLEN_BITS-1:0];
                stwd_pkg::CFG_TARGET_WORD:
                    target_word_reg <= cfg_wdata[stwd_pkg::MAX_WORD_BITS-1:0];
                default:
                    threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg      <= '0;
            prev_prev_sample_reg <= '0;
            spike_in_bin_reg     <= 1'b0;
            pending_start_reg    <= 1'b1;
            window_start_reg     <= '0;
        end
        else if (accept)
        begin
            prev_prev_sample_reg <= prev_sample_reg;
            prev_sample_reg      <= samples.sample;
            window_start_reg     <= start_time;
            // Restart the bin at the next item after a close.
            pending_start_reg    <= close;
            spike_in_bin_reg     <= close ? 1'b0 : spike_seen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && close)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && close)
        begin
            word_detected_reg <= match;
            bin_bit_reg       <= spike_seen;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.word_detected = word_detected_reg;
    assign results.bin_bit       = bin_bit_reg;

endmodule

>>> rtl/stwd_word_matcher.sv
// Bit history, saturating bit count and match flag of the word detector.
// Depends on stwd_pkg.

module stwd_word_matcher
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stwd_pkg::insert_req_t                insert,
    input  logic                                 bin_close,
    input  logic [stwd_pkg::WLEN_BITS-1:0]       word_length,
    input  logic [stwd_pkg::MAX_WORD_BITS-1:0]   target_word,
    output logic                                 match
);

    logic [stwd_pkg::MAX_WORD_BITS-1:0] bit_history_reg;
    logic [stwd_pkg::MAX_WORD_BITS-1:0] bit_history_next;
    logic [stwd_pkg::CNT_BITS-1:0]      bits_seen_reg;
    logic [stwd_pkg::CNT_BITS-1:0]      bits_seen_next;
    logic                               match_pending_reg;
    logic                               match_pending_next;
    logic [stwd_pkg::CNT_BITS-1:0]      eff_len;
    logic [stwd_pkg::MAX_WORD_BITS-1:0] len_mask;

    // Zero acts as one, anything above the history depth acts as the depth.
    always_comb
    begin
        if (word_length == '0)
            eff_len = stwd_pkg::CNT_BITS'(1);
        else if (32'(word_length) > stwd_pkg::MAX_WORD_BITS)
            eff_len = stwd_pkg::CNT_BITS'(stwd_pkg::MAX_WORD_BITS);
        else
            eff_len = stwd_pkg::CNT_BITS'(word_length);
    end

    assign len_mask = ~({stwd_pkg::MAX_WORD_BITS{1'b1}} << eff_len);

    always_comb
    begin
        bit_history_next = bit_history_reg;
        bits_seen_next   = bits_seen_reg;
        match            = match_pending_reg;
        if (insert.valid)
        begin
            bit_history_next = (bit_history_reg << 1)
                             | stwd_pkg::MAX_WORD_BITS'(insert.bit_value);
            if (bits_seen_reg < eff_len)
                bits_seen_next = bits_seen_reg + stwd_pkg::CNT_BITS'(1);
            else
                bits_seen_next = eff_len;
            if (bits_seen_next >= eff_len)
                match = (bit_history_next & len_mask) == (target_word & len_mask);
        end
        // Drop the flag once the closing bin has reported it.
        match_pending_next = bin_close ? 1'b0 : match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_history_reg   <= '0;
            bits_seen_reg     <= '0;
            match_pending_reg <= 1'b0;
        end
        else
        begin
            bit_history_reg   <= bit_history_next;
            bits_seen_reg     <= bits_seen_next;
            match_pending_reg <= match_pending_next;
        end
    end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for spike_train_word_detector_top: a directed table, then random phases.
// Depends on stwd_pkg and the channel interfaces in rtl/stwd_if.sv; a local bin predictor
// supplies the expected word_detected / bin_bit of every closed bin that the directed table does not type.

module testbench;

    typedef logic signed [stwd_pkg::SAMPLE_BITS-1:0] sample_t;
    typedef logic [stwd_pkg::TIME_BITS-1:0]          tstamp_t;

    typedef struct packed {
        logic det;
        logic bbit;
    } bin_result_t;

    typedef struct packed {
        logic                               is_cfg;
        stwd_pkg::cfg_idx_t                 reg_idx;
        logic [stwd_pkg::CFG_DATA_BITS-1:0] wdata;
        sample_t                            smp;
        tstamp_t                            tns;
        logic                               typed;
        logic                               exp_det;
        logic                               exp_bit;
    } plan_row_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_SPARSE} rx_mode_t;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 125;

    // Short names for the register indexes used in the directed table.
    localparam stwd_pkg::cfg_idx_t R_THR  = stwd_pkg::CFG_THRESHOLD;
    localparam stwd_pkg::cfg_idx_t R_BIN  = stwd_pkg::CFG_BIN_LENGTH;
    localparam stwd_pkg::cfg_idx_t R_WLEN = stwd_pkg::CFG_WORD_LENGTH;
    localparam stwd_pkg::cfg_idx_t R_TGT  = stwd_pkg::CFG_TARGET_WORD;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [stwd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [stwd_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

    stwd_sample_if samples();
    stwd_result_if results();

    spike_train_word_detector_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .samples   (samples),
        .results   (results)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor copy of the registers and of the detector state.
    sample_t                            thr;
    tstamp_t                            bin_len;
    logic [stwd_pkg::WLEN_BITS-1:0]     wlen;
    logic [stwd_pkg::MAX_WORD_BITS-1:0] target;
    sample_t                            prev1;
    sample_t                            prev2;
    logic                               spiked;
    logic                               start_due;
    tstamp_t                            bin_start;
    logic [stwd_pkg::MAX_WORD_BITS-1:0] history;
    int unsigned                        bits_seen;
    logic                               match_due;

    bin_result_t bins_due[$];
    int          mismatches = 0;

    // Tags that travel with the item on the sample channel.
    logic row_typed;
    logic row_det;
    logic row_bit;

    rx_mode_t                 stall_mode = RX_ALWAYS;
    logic [15:0]              stall_pat  = 16'hB3C5;

    plan_row_t plan [31] = '{
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        // first bin after reset: zero bit, too few bits for a compare
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'd60000001,   1'b1, 1'b0, 1'b0},
        '{1'b1, R_BIN,  48'd0,              16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b1, R_WLEN, 48'd0,              16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b1, R_TGT,  48'd1,              16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b1, R_THR,  48'hFFFF_FFFF_8000, 16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        // lowest threshold: a flat zero followed by the minimum is a peak
        '{1'b0, R_THR,  48'd0,              16'h8000, 48'd100,        1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'h8000, 48'd101,        1'b1, 1'b1, 1'b1},
        '{1'b0, R_THR,  48'd0,              16'h8000, 48'd102,        1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'h8000, 48'd103,        1'b1, 1'b0, 1'b0},
        '{1'b1, R_THR,  48'h0000_0000_7FFF, 16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        // highest threshold: nothing can exceed it
        '{1'b0, R_THR,  48'd0,              16'h7FFF, 48'd200,        1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'h7FFF, 48'd201,        1'b1, 1'b0, 1'b0},
        '{1'b1, R_THR,  48'd0,              16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd5,   48'd300,        1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'd301,        1'b0, 1'b0, 1'b0},
        // peak found on the very sample that closes the bin
        '{1'b0, R_THR,  48'd0,              16'sd10,  48'd400,        1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd3,   48'd401,        1'b0, 1'b0, 1'b0},
        '{1'b1, R_BIN,  48'd1000,           16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        // timestamp steps back and closes the bin
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'd500,        1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'd499,        1'b0, 1'b0, 1'b0},
        // timestamp wraps through zero
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'hFFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'h10,         1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd0,   48'h3F0,        1'b0, 1'b0, 1'b0},
        '{1'b1, R_WLEN, 48'd31,             16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b1, R_TGT,  48'hFFFF,           16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b1, R_BIN,  48'hFFFF_FFFF_FFFF, 16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        // longest bin: full-scale elapsed time is not past it
        '{1'b0, R_THR,  48'd0,              16'hFFFB, 48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd7,   48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{1'b1, R_BIN,  48'd2,              16'sd0,   48'd0,          1'b0, 1'b0, 1'b0},
        '{1'b0, R_THR,  48'd0,              16'sd1,   48'd3,          1'b0, 1'b0, 1'b0}
    };

    function automatic int unsigned word_len_eff();
        if (wlen == '0)
            return 1;
        if (wlen > stwd_pkg::MAX_WORD_BITS)
            return stwd_pkg::MAX_WORD_BITS;
        return 32'(wlen);
    endfunction

    task automatic shift_in_bit(input logic b);
        int unsigned                        len;
        logic [stwd_pkg::MAX_WORD_BITS-1:0] m;
        len = word_len_eff();
        m   = (len >= stwd_pkg::MAX_WORD_BITS) ? '1
            : stwd_pkg::MAX_WORD_BITS'((32'd1 << len) - 1);
        history = {history[stwd_pkg::MAX_WORD_BITS-2:0], b};
        if (bits_seen < len)
            bits_seen++;
        if (bits_seen > len)
            bits_seen = len;
        if (bits_seen >= len)
            match_due = ((history & m) == (target & m));
    endtask

    task automatic predict_bin(input sample_t s, input tstamp_t t,
                               output logic fired, output bin_result_t res);
        logic    peak;
        tstamp_t elapsed;
        fired = 1'b0;
        res   = '0;
        if (start_due)
        begin
            bin_start = t;
            start_due = 1'b0;
        end
        peak  = (prev2 <= prev1) && (prev1 >= s) && (prev1 > thr);
        prev2 = prev1;
        prev1 = s;
        if (peak && !spiked)
        begin
            spiked = 1'b1;
            shift_in_bit(1'b1);
        end
        elapsed = t - bin_start;
        if (elapsed > bin_len)
        begin
            if (!spiked)
                shift_in_bit(1'b0);
            fired     = 1'b1;
            res.det   = match_due;
            res.bbit  = spiked;
            spiked    = 1'b0;
            start_due = 1'b1;
            match_due = 1'b0;
        end
    endtask

    // Check results, track register writes and predict, all on the same edge.
    always @(posedge clk)
    begin
        bin_result_t got;
        bin_result_t want;
        bin_result_t pred;
        logic        fired;
        if (!rst_n)
        begin
            thr       = stwd_pkg::THRESHOLD_RST;
            bin_len   = stwd_pkg::BIN_LENGTH_RST;
            wlen      = stwd_pkg::WORD_LENGTH_RST;
            target    = stwd_pkg::TARGET_WORD_RST;
            prev1     = '0;
            prev2     = '0;
            spiked    = 1'b0;
            start_due = 1'b1;
            bin_start = '0;
            history   = '0;
            bits_seen = 0;
            match_due = 1'b0;
            bins_due.delete();
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = bin_result_t'{results.word_detected, results.bin_bit};
                if (bins_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual det=%b bit=%b",
                             $time, got.det, got.bbit);
                end
                else
                begin
                    want = bins_due.pop_front();
                    if (got.det !== want.det)
                    begin
                        mismatches++;
                        $display("%0t: word_detected expected %b actual %b",
                                 $time, want.det, got.det);
                    end
                    if (got.bbit !== want.bbit)
                    begin
                        mismatches++;
                        $display("%0t: bin_bit expected %b actual %b",
                                 $time, want.bbit, got.bbit);
                    end
                end
            end
            if (cfg_we)
            begin
                case (stwd_pkg::cfg_idx_t'(cfg_index))
                    stwd_pkg::CFG_THRESHOLD:
                        thr     = cfg_wdata[stwd_pkg::SAMPLE_BITS-1:0];
                    stwd_pkg::CFG_BIN_LENGTH:
                        bin_len = cfg_wdata[stwd_pkg::TIME_BITS-1:0];
                    stwd_pkg::CFG_WORD_LENGTH:
                        wlen    = cfg_wdata[stwd_pkg::WLEN_BITS-1:0];
                    stwd_pkg::CFG_TARGET_WORD:
                        target  = cfg_wdata[stwd_pkg::MAX_WORD_BITS-1:0];
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
            begin
                predict_bin(samples.sample, samples.time_ns, fired, pred);
                if (row_typed)
                    bins_due.push_back(bin_result_t'{row_det, row_bit});
                else if (fired)
                    bins_due.push_back(pred);
            end
        end
    end

    // Result side stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_pat <= 16'($urandom) | 16'h0001;
        else
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
        case (stall_mode)
            RX_ALWAYS:  results.ready <= 1'b1;
            RX_PATTERN: results.ready <= stall_pat[15];
            default:    results.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send(input sample_t s, input tstamp_t t,
                        input logic typed, input logic det, input logic bb);
        samples.valid   <= 1'b1;
        samples.sample  <= s;
        samples.time_ns <= t;
        row_typed       <= typed;
        row_det         <= det;
        row_bit         <= bb;
        do
            @(posedge clk);
        while (!samples.ready);
    endtask

    // Drop valid and let the output register drain before touching registers.
    task automatic wait_idle();
        samples.valid <= 1'b0;
        do
            @(posedge clk);
        while (bins_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input stwd_pkg::cfg_idx_t idx,
                             input logic [stwd_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int                                 burst_left;
        int                                 gap;
        int                                 v;
        logic                               gaps_on;
        sample_t                            s;
        sample_t                            phase_thr;
        tstamp_t                            t;
        logic [stwd_pkg::WLEN_BITS-1:0]     phase_wlen;
        logic [stwd_pkg::MAX_WORD_BITS-1:0] phase_target;
        tstamp_t                            phase_bin;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        samples.valid   <= 1'b0;
        samples.sample  <= '0;
        samples.time_ns <= '0;
        row_typed       <= 1'b0;
        row_det         <= 1'b0;
        row_bit         <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].wdata);
            end
            else
                send(plan[i].smp, plan[i].tns, plan[i].typed, plan[i].exp_det, plan[i].exp_bit);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                phase_thr = 16'h8000;
            else if (ph == 1)
                phase_thr = 16'h7FFF;
            else if ($urandom_range(0, 3) == 0)
                phase_thr = sample_t'($urandom);
            else
                phase_thr = sample_t'(int'($urandom_range(0, 400)) - 200);

            if (ph == 0)
                phase_wlen = '0;
            else if (ph == 1)
                phase_wlen = 5'd31;
            else if (ph == 2)
                phase_wlen = 5'd16;
            else if (ph == 3)
                phase_wlen = 5'd17;
            else if ($urandom_range(0, 4) == 0)
                phase_wlen = stwd_pkg::WLEN_BITS'($urandom_range(0, 31));
            else
                phase_wlen = stwd_pkg::WLEN_BITS'($urandom_range(1, 6));

            // no spike can pass the top threshold, so an all-zero word matches once history is all zero
            phase_target = (ph == 1) ? '0 : stwd_pkg::MAX_WORD_BITS'($urandom);

            if (ph == 0)
                phase_bin = '0;
            else if (ph == 5)
                phase_bin = tstamp_t'($urandom_range(150, 300));
            else
                phase_bin = tstamp_t'($urandom_range(0, 24));

            wait_idle();
            write_reg(stwd_pkg::CFG_THRESHOLD, {$urandom, 16'(phase_thr)});
            write_reg(stwd_pkg::CFG_BIN_LENGTH, phase_bin);
            write_reg(stwd_pkg::CFG_WORD_LENGTH, stwd_pkg::CFG_DATA_BITS'(phase_wlen));
            write_reg(stwd_pkg::CFG_TARGET_WORD, stwd_pkg::CFG_DATA_BITS'(phase_target));

            stall_mode <= rx_mode_t'(ph % 3);
            gaps_on    = (ph % 5 != 2);
            burst_left = $urandom_range(1, 20);
            if (ph % 4 == 3)
                t = 48'hFFFF_FFFF_FFFF - tstamp_t'($urandom_range(0, 200));
            else
                t = tstamp_t'({$urandom, $urandom});

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // hover around the threshold so peaks come and go
                    v = int'(phase_thr) + int'($urandom_range(0, 48)) - 24;
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                    s = sample_t'(v);
                end
                else
                    s = sample_t'($urandom);
                if ($urandom_range(0, 29) == 0)
                    t = t - tstamp_t'($urandom_range(1, 50));
                else
                    t = t + tstamp_t'($urandom_range(0, 8));

                send(s, t, 1'b0, 1'b0, 1'b0);

                if (n == ITEMS_PER_PHASE / 2 && ph % 4 == 1)
                begin
                    // hold until the result side has caught up
                    samples.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (bins_due.size() != 0);
                end
                else if (gaps_on)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap = $urandom_range(1, 6);
                        samples.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
        end

        samples.valid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
